// File: src/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg - shared types and constants of the selective-repeat sender window
// Opcodes, register indexes, field widths and the controller/datapath buses.
// ----------------------------------------------------------------------------
package srsw_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int CHUNK_W  = 12;
	localparam int CNT_W    = 13;
	localparam int AGE_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// acknowledge bitmap is kept in words of this many chunks
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// parameter defaults
	localparam int DEF_MAX_CHUNKS   = 4096;
	localparam int DEF_WINDOW_SLOTS = 8;

	localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd100;
	localparam logic [AGE_W-1:0] AGE_MAX     = 16'hFFFF;

	// item opcodes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
	localparam logic [OP_W-1:0] OP_START = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

	// result kinds
	localparam logic KIND_SEND   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;        // latch the input beat
		logic clr_start;   // free all slots, restart the bitmap clear
		logic clr_step;    // zero one bitmap row
		logic tick;        // age busy slots, free timed-out ones
		logic ack_rd;      // read the acknowledged chunk's row
		logic ack_wr;      // set its bit, free its slot
		logic scan_init;   // start the refill scan at the lowest open row
		logic scan_rd;     // read the current scan row
		logic scan_ld;     // build the candidate mask of that row
		logic emit_send;   // fill the lowest free slot, send a chunk
		logic scan_next;   // advance to the next row
		logic emit_status; // closing status beat
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic ack_in_range;
		logic clr_last;
		logic row_in_range;
		logic cand_any;
		logic free_any;
		logic seen;
	} sts_t;

endpackage

// File: src/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srsw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl - sequencer of the selective-repeat sender window
// Walks each item through dispatch, bitmap update, refill scan and status.
// ----------------------------------------------------------------------------
module srsw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  srsw_pkg::sts_t   sts,
	output srsw_pkg::cmd_t   cmd
);
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISP      = 4'd1;
	localparam logic [3:0] S_CLEAR     = 4'd2;
	localparam logic [3:0] S_ACK_RD    = 4'd3;
	localparam logic [3:0] S_ACK_WR    = 4'd4;
	localparam logic [3:0] S_SCAN_INIT = 4'd5;
	localparam logic [3:0] S_SCAN_RD   = 4'd6;
	localparam logic [3:0] S_SCAN_LD   = 4'd7;
	localparam logic [3:0] S_SCAN_EMIT = 4'd8;
	localparam logic [3:0] S_STATUS    = 4'd9;

	logic [3:0] state_q, state_d;
	logic       from_start_q, from_start_d;

	// state register; reset enters the bitmap clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			from_start_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			from_start_q <= from_start_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		from_start_d = from_start_q;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					srsw_pkg::OP_START: begin
						cmd.clr_start = 1'b1;
						from_start_d  = 1'b1;
						state_d       = S_CLEAR;
					end
					srsw_pkg::OP_ACK: begin
						state_d = sts.ack_in_range ? S_ACK_RD : S_SCAN_INIT;
					end
					srsw_pkg::OP_TICK: begin
						cmd.tick = 1'b1;
						state_d  = S_SCAN_INIT;
					end
					default: begin
						state_d = S_SCAN_INIT;
					end
				endcase
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d      = from_start_q ? S_SCAN_INIT : S_IDLE;
					from_start_d = 1'b0;
				end
			end
			S_ACK_RD: begin
				cmd.ack_rd = 1'b1;
				state_d    = S_ACK_WR;
			end
			S_ACK_WR: begin
				cmd.ack_wr = 1'b1;
				state_d    = S_SCAN_INIT;
			end
			S_SCAN_INIT: begin
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (sts.row_in_range) begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_LD;
				end else begin
					state_d = S_STATUS;
				end
			end
			S_SCAN_LD: begin
				cmd.scan_ld = 1'b1;
				state_d     = S_SCAN_EMIT;
			end
			S_SCAN_EMIT: begin
				// one send per cycle; stop once slots are full and an open chunk is known
				if (sts.cand_any && sts.free_any) begin
					cmd.emit_send = 1'b1;
				end else if (!sts.free_any && sts.seen) begin
					state_d = S_STATUS;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_STATUS: begin
				cmd.emit_status = 1'b1;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: src/srsw_dp.sv
// ----------------------------------------------------------------------------
// srsw_dp - datapath of the selective-repeat sender window
// Config registers, slot lanes, acknowledge bitmap RAM, scan pointer and the
// result registers.
// ----------------------------------------------------------------------------
module srsw_dp #(
	parameter int MAX_CHUNKS   = srsw_pkg::DEF_MAX_CHUNKS,
	parameter int WINDOW_SLOTS = srsw_pkg::DEF_WINDOW_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [srsw_pkg::OP_W-1:0]        op,
	input  logic [srsw_pkg::CHUNK_W-1:0]     ack_chunk,
	input  logic                             cfg_we,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [srsw_pkg::CFG_W-1:0]       cfg_data,
	input  srsw_pkg::cmd_t                   cmd,
	output srsw_pkg::sts_t                   sts,
	output logic                             strobe,
	output logic                             kind,
	output logic [srsw_pkg::CHUNK_W-1:0]     send_chunk,
	output logic                             all_acked,
	output logic                             last
);
	localparam int WW     = srsw_pkg::WORD_W;
	localparam int BW     = srsw_pkg::BIT_W;
	localparam int ROWS   = (MAX_CHUNKS + WW - 1) / WW;
	localparam int ROWP_W = $clog2(ROWS + 1);
	localparam int ROWA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CH_W   = ROWP_W + BW;
	localparam int SL_W   = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int AGE_W  = srsw_pkg::AGE_W;
	localparam int CNT_W  = srsw_pkg::CNT_W;

	// registers
	logic [srsw_pkg::OP_W-1:0]    op_q;
	logic [srsw_pkg::CHUNK_W-1:0] ack_q;
	logic [CNT_W-1:0]             chunk_count_q;
	logic [AGE_W-1:0]             timeout_q;
	logic [WINDOW_SLOTS-1:0]      slot_busy_q;
	logic [CH_W-1:0]              slot_chunk_q [WINDOW_SLOTS];
	logic [AGE_W-1:0]             slot_age_q   [WINDOW_SLOTS];
	logic [ROWP_W-1:0]            clr_ptr_q;
	logic [ROWP_W-1:0]            low_row_q;
	logic [ROWP_W-1:0]            ptr_q;
	logic [WW-1:0]                cand_q;
	logic                         seen_q;
	logic                         strobe_q;
	logic                         kind_q;
	logic [srsw_pkg::CHUNK_W-1:0] send_chunk_q;
	logic                         all_acked_q;
	logic                         last_q;

	// combinational
	logic [CNT_W-1:0]  eff_n;
	logic [CH_W-1:0]   ack_idx;
	logic [ROWP_W-1:0] ack_row;
	logic              ack_in_range;
	logic [CH_W-1:0]   row_base;
	logic              row_in_range;
	logic [31:0]       row_left;
	logic [BW:0]       row_left_c;
	logic [WW-1:0]     below_mask;
	logic [WW-1:0]     outst_mask;
	logic [WW-1:0]     rdata;
	logic [WW-1:0]     open_mask;
	logic              free_any;
	logic [SL_W-1:0]   free_idx;
	logic [BW-1:0]     cand_bit;
	logic [CH_W-1:0]   fill_chunk;
	logic              ram_we;
	logic [ROWA_W-1:0] ram_waddr;
	logic [WW-1:0]     ram_wdata;
	logic              ram_re;
	logic [ROWA_W-1:0] ram_raddr;

	// effective chunk count, capped at the bitmap size
	assign eff_n = (32'(chunk_count_q) > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS) : chunk_count_q;

	assign ack_idx      = CH_W'(ack_q);
	assign ack_row      = ack_idx[CH_W-1:BW];
	assign ack_in_range = 32'(ack_q) < 32'(eff_n);

	// current scan row against the chunk count
	assign row_base     = {ptr_q, {BW{1'b0}}};
	assign row_in_range = 32'(row_base) < 32'(eff_n);
	assign row_left     = 32'(eff_n) - 32'(row_base);
	assign row_left_c   = (row_left >= 32'(WW)) ? (BW + 1)'(WW) : (BW + 1)'(row_left);
	assign below_mask   = row_left_c[BW] ? '1 : ((WW'(1) << row_left_c[BW-1:0]) - WW'(1));

	// chunks of this row already held by a busy slot
	always_comb begin
		outst_mask = '0;
		for (int s = 0; s < WINDOW_SLOTS; s++) begin
			if (slot_busy_q[s] && (slot_chunk_q[s][CH_W-1:BW] == ptr_q)) begin
				outst_mask[slot_chunk_q[s][BW-1:0]] = 1'b1;
			end
		end
	end

	assign open_mask = ~rdata & below_mask;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int s = WINDOW_SLOTS - 1; s >= 0; s--) begin
			if (!slot_busy_q[s]) begin
				free_idx = SL_W'(s);
			end
		end
	end
	assign free_any = ~&slot_busy_q;

	// lowest candidate chunk of the row
	always_comb begin
		cand_bit = '0;
		for (int b = WW - 1; b >= 0; b--) begin
			if (cand_q[b]) begin
				cand_bit = BW'(b);
			end
		end
	end
	assign fill_chunk = {ptr_q, cand_bit};

	// bitmap RAM ports
	assign ram_we    = cmd.clr_step | cmd.ack_wr;
	assign ram_waddr = cmd.clr_step ? clr_ptr_q[ROWA_W-1:0] : ack_row[ROWA_W-1:0];
	assign ram_wdata = cmd.clr_step ? '0 : (rdata | (WW'(1) << ack_idx[BW-1:0]));
	assign ram_re    = cmd.scan_rd | cmd.ack_rd;
	assign ram_raddr = cmd.scan_rd ? ptr_q[ROWA_W-1:0] : ack_row[ROWA_W-1:0];

	srsw_ram #(
		.WIDTH (WW),
		.DEPTH (ROWS)
	) u_acked_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= '0;
			timeout_q     <= srsw_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srsw_pkg::REG_CHUNK_COUNT:   chunk_count_q <= cfg_data[CNT_W-1:0];
				srsw_pkg::REG_TIMEOUT_TICKS: timeout_q     <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// input beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			ack_q <= ack_chunk;
		end
	end

	// slot busy bits and ages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_busy_q <= '0;
			for (int s = 0; s < WINDOW_SLOTS; s++) begin
				slot_age_q[s] <= '0;
			end
		end else if (cmd.clr_start) begin
			slot_busy_q <= '0;
			for (int s = 0; s < WINDOW_SLOTS; s++) begin
				slot_age_q[s] <= '0;
			end
		end else if (cmd.tick) begin
			for (int s = 0; s < WINDOW_SLOTS; s++) begin
				logic [AGE_W-1:0] nage;
				nage = (slot_age_q[s] != srsw_pkg::AGE_MAX) ? slot_age_q[s] + AGE_W'(1)
					: slot_age_q[s];
				if (slot_busy_q[s]) begin
					if (nage > timeout_q) begin
						slot_busy_q[s] <= 1'b0;
						slot_age_q[s]  <= '0;
					end else begin
						slot_age_q[s] <= nage;
					end
				end
			end
		end else if (cmd.ack_wr) begin
			for (int s = 0; s < WINDOW_SLOTS; s++) begin
				if (slot_busy_q[s] && (slot_chunk_q[s] == ack_idx)) begin
					slot_busy_q[s] <= 1'b0;
					slot_age_q[s]  <= '0;
				end
			end
		end else if (cmd.emit_send) begin
			slot_busy_q[free_idx] <= 1'b1;
			slot_age_q[free_idx]  <= '0;
		end
	end

	// slot chunk numbers, meaningful only while busy
	always_ff @(posedge clk) begin
		if (cmd.emit_send) begin
			slot_chunk_q[free_idx] <= fill_chunk;
		end
	end

	// clear pointer, scan pointer and low-water row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
			low_row_q <= '0;
			ptr_q     <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (cmd.clr_start) begin
				clr_ptr_q <= '0;
				low_row_q <= '0;
			end else if (cmd.clr_step) begin
				clr_ptr_q <= clr_ptr_q + ROWP_W'(1);
			end
			if (cmd.scan_init) begin
				ptr_q  <= low_row_q;
				seen_q <= 1'b0;
			end else if (cmd.scan_next) begin
				ptr_q <= ptr_q + ROWP_W'(1);
			end else if (cmd.scan_ld) begin
				seen_q <= seen_q | (|open_mask);
				// rows below the low-water mark are fully acknowledged
				if ((ptr_q == low_row_q) && (&rdata)) begin
					low_row_q <= low_row_q + ROWP_W'(1);
				end
			end
		end
	end

	// candidate mask of the current row
	always_ff @(posedge clk) begin
		if (cmd.scan_ld) begin
			cand_q <= open_mask & ~outst_mask;
		end else if (cmd.emit_send) begin
			cand_q[cand_bit] <= 1'b0;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_send | cmd.emit_status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_send) begin
			kind_q       <= srsw_pkg::KIND_SEND;
			send_chunk_q <= srsw_pkg::CHUNK_W'(fill_chunk);
			all_acked_q  <= 1'b0;
			last_q       <= 1'b0;
		end else if (cmd.emit_status) begin
			kind_q       <= srsw_pkg::KIND_STATUS;
			send_chunk_q <= '0;
			all_acked_q  <= ~seen_q;
			last_q       <= 1'b1;
		end
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign send_chunk = send_chunk_q;
	assign all_acked  = all_acked_q;
	assign last       = last_q;

	// status to the controller
	assign sts.op           = op_q;
	assign sts.ack_in_range = ack_in_range;
	assign sts.clr_last     = (clr_ptr_q == ROWP_W'(ROWS - 1));
	assign sts.row_in_range = row_in_range;
	assign sts.cand_any     = |cand_q;
	assign sts.free_any     = free_any;
	assign sts.seen         = seen_q;

	// two busy slots never carry the same chunk
	logic dup_chunk;
	always_comb begin
		dup_chunk = 1'b0;
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			for (int j = i + 1; j < WINDOW_SLOTS; j++) begin
				if (slot_busy_q[i] && slot_busy_q[j] && (slot_chunk_q[i] == slot_chunk_q[j])) begin
					dup_chunk = 1'b1;
				end
			end
		end
	end

	a_no_dup_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		!dup_chunk)
		else $error("two busy slots carry the same chunk");

	a_send_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_send |-> (free_any && (|cand_q)))
		else $error("send issued without a free slot or candidate");

	a_fill_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_send |=> slot_busy_q[$past(free_idx)])
		else $error("filled slot not marked busy");

	a_send_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (kind_q == srsw_pkg::KIND_SEND)) |-> !all_acked_q)
		else $error("send beat reports transfer complete");

endmodule

// File: src/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window - sender side of a selective-repeat transfer
// Keeps WINDOW_SLOTS outstanding chunks, an acknowledge bitmap and slot ages.
// ----------------------------------------------------------------------------
// Usage:
//   Configure chunk_count and timeout_ticks through cfg_we/cfg_index/cfg_data
//   while busy is low. An item (op, ack_chunk) is taken when start is high and
//   busy is low: op tick ages slots, ack marks a chunk and frees its slot,
//   start clears the bitmap and frees every slot.
//   Each item produces zero or more send beats (kind 0, one per refilled slot,
//   lowest chunk first) and one status beat (kind 1, last 1). Every beat is
//   on the result ports for one cycle, marked by strobe; the receiver cannot
//   stall, so no back-pressure exists.
//   Scan: the refill scan walks the bitmap RAM one 32-chunk row at a time,
//   starting at the lowest row not yet fully acknowledged; each row is read,
//   turned into a candidate mask and then drained by send beats. An ack in
//   range first does a read-modify-write of its bitmap row. A start item
//   first clears the bitmap, one row per cycle. The bitmap RAM's single read
//   port sets the scan rate.
//   Reset: slots are freed, registers take their reset values, and the same
//   clearing pass runs with busy high before the first item is taken.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
	parameter int MAX_CHUNKS   = srsw_pkg::DEF_MAX_CHUNKS,
	parameter int WINDOW_SLOTS = srsw_pkg::DEF_WINDOW_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [srsw_pkg::OP_W-1:0]        op,
	input  logic [srsw_pkg::CHUNK_W-1:0]     ack_chunk,
	input  logic                             cfg_we,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [srsw_pkg::CFG_W-1:0]       cfg_data,
	output logic                             strobe,
	output logic                             kind,
	output logic [srsw_pkg::CHUNK_W-1:0]     send_chunk,
	output logic                             all_acked,
	output logic                             last
);
	srsw_pkg::cmd_t cmd;
	srsw_pkg::sts_t sts;

	// sequencer
	srsw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// slots, bitmap and result registers
	srsw_dp #(
		.MAX_CHUNKS   (MAX_CHUNKS),
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.ack_chunk  (ack_chunk),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.strobe     (strobe),
		.kind       (kind),
		.send_chunk (send_chunk),
		.all_acked  (all_acked),
		.last       (last)
	);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for selective_repeat_sender_window
// Drives tick/ack/start items with random hold-off and predicts every send
// and status beat from a behavioral copy of the window, bitmap and slot ages.
// Covers register extremes, timeout changes, and random transfers.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXC  = srsw_pkg::DEF_MAX_CHUNKS;
	localparam int SLOTS = srsw_pkg::DEF_WINDOW_SLOTS;

	// op code 3 is unused by the block
	localparam logic [srsw_pkg::OP_W-1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [srsw_pkg::OP_W-1:0]    op;
		logic [srsw_pkg::CHUNK_W-1:0] ack;
	} item_t;

	typedef struct packed {
		logic                         kind;
		logic [srsw_pkg::CHUNK_W-1:0] send_chunk;
		logic                         all_acked;
		logic                         last;
	} beat_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           start     = 1'b0;
	logic [srsw_pkg::OP_W-1:0]      op        = srsw_pkg::OP_TICK;
	logic [srsw_pkg::CHUNK_W-1:0]   ack_chunk = '0;
	logic                           cfg_we    = 1'b0;
	logic [srsw_pkg::CFG_IDX_W-1:0] cfg_index = srsw_pkg::REG_CHUNK_COUNT;
	logic [srsw_pkg::CFG_W-1:0]     cfg_data  = '0;
	logic                           busy;
	logic                           strobe;
	logic                           kind;
	logic [srsw_pkg::CHUNK_W-1:0]   send_chunk;
	logic                           all_acked;
	logic                           last;

	// shadow of the window state and registers
	logic [srsw_pkg::CNT_W-1:0]   cfg_count   = '0;
	logic [srsw_pkg::AGE_W-1:0]   cfg_timeout = srsw_pkg::TIMEOUT_RST;
	bit [MAXC-1:0]                acked_map   = '0;
	bit                           slot_busy [SLOTS];
	logic [srsw_pkg::CHUNK_W-1:0] slot_chunk [SLOTS];
	logic [srsw_pkg::AGE_W-1:0]   slot_age [SLOTS];

	item_t pending_items[$];
	beat_t beats_due[$];

	int items_pushed = 0;
	int items_taken  = 0;
	int beats_seen   = 0;
	int sends_seen   = 0;
	int reg_writes   = 0;
	int err_cnt      = 0;
	int gap_max      = 0;
	int gap_left     = 0;
	logic  drv_start;
	item_t drv_item;
	beat_t got_beat;
	beat_t want_beat;

	selective_repeat_sender_window u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.ack_chunk  (ack_chunk),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.kind       (kind),
		.send_chunk (send_chunk),
		.all_acked  (all_acked),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		for (int s = 0; s < SLOTS; s++) begin
			slot_busy[s]  = 1'b0;
			slot_chunk[s] = '0;
			slot_age[s]   = '0;
		end
	end

	function automatic bit chunk_outstanding(input int c);
		bit hit;
		hit = 1'b0;
		for (int s = 0; s < SLOTS; s++)
			if (slot_busy[s] && slot_chunk[s] == c[srsw_pkg::CHUNK_W-1:0])
				hit = 1'b1;
		return hit;
	endfunction

	function automatic int eff_count();
		return (cfg_count > MAXC) ? MAXC : int'(cfg_count);
	endfunction

	// advance the window by one item and queue the beats it causes
	task automatic window_step(input logic [srsw_pkg::OP_W-1:0] opc,
		input logic [srsw_pkg::CHUNK_W-1:0] ack);
		int n;
		int c;
		bit room;
		bit done;
		int fills[$];
		beat_t b;
		n = eff_count();
		case (opc)
			srsw_pkg::OP_START: begin
				acked_map = '0;
				for (int s = 0; s < SLOTS; s++) begin
					slot_busy[s] = 1'b0;
					slot_age[s]  = '0;
				end
			end
			srsw_pkg::OP_ACK: begin
				if (ack < n) begin
					acked_map[ack] = 1'b1;
					for (int s = 0; s < SLOTS; s++) begin
						if (slot_busy[s] && slot_chunk[s] == ack) begin
							slot_busy[s] = 1'b0;
							slot_age[s]  = '0;
						end
					end
				end
			end
			srsw_pkg::OP_TICK: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_busy[s]) begin
						if (slot_age[s] != srsw_pkg::AGE_MAX)
							slot_age[s] = slot_age[s] + 1'b1;
						if (slot_age[s] > cfg_timeout) begin
							slot_busy[s] = 1'b0;
							slot_age[s]  = '0;
						end
					end
				end
			end
			default: ;
		endcase

		// refill free slots, lowest slot first, lowest eligible chunk first
		c    = 0;
		room = 1'b1;
		for (int s = 0; s < SLOTS && room; s++) begin
			if (!slot_busy[s]) begin
				while (c < n && (acked_map[c] || chunk_outstanding(c)))
					c++;
				if (c >= n) begin
					room = 1'b0;
				end else begin
					slot_busy[s]  = 1'b1;
					slot_chunk[s] = c[srsw_pkg::CHUNK_W-1:0];
					slot_age[s]   = '0;
					fills.push_back(c);
					c++;
				end
			end
		end

		done = 1'b1;
		for (c = 0; c < n; c++)
			if (!acked_map[c])
				done = 1'b0;

		foreach (fills[i]) begin
			b = '{kind: srsw_pkg::KIND_SEND, send_chunk: fills[i][srsw_pkg::CHUNK_W-1:0],
				all_acked: done, last: 1'b0};
			beats_due.push_back(b);
		end
		b = '{kind: srsw_pkg::KIND_STATUS, send_chunk: '0, all_acked: done, last: 1'b1};
		beats_due.push_back(b);
	endtask

	// item driver: random hold-off drawn at each accepted beat
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			drv_start = start;
			if (start && !busy) begin
				window_step(op, ack_chunk);
				items_taken++;
				drv_start = 1'b0;
				gap_left  = $urandom_range(gap_max, 0);
			end
			if (!drv_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0) begin
					drv_item = pending_items.pop_front();
					op        <= drv_item.op;
					ack_chunk <= drv_item.ack;
					drv_start = 1'b1;
				end
			end
			start <= drv_start;
		end
	end

	// result monitor: every strobed beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			beats_seen++;
			got_beat = '{kind: kind, send_chunk: send_chunk, all_acked: all_acked, last: last};
			if (beats_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected beat %0d: kind %0d chunk %0d all_acked %0d last %0d",
						beats_seen, kind, send_chunk, all_acked, last);
			end else begin
				want_beat = beats_due.pop_front();
				if (want_beat.kind == srsw_pkg::KIND_SEND)
					sends_seen++;
				if (got_beat !== want_beat) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"mismatch at beat %0d: expected kind %0d chunk %0d ",
							"all_acked %0d last %0d, got kind %0d chunk %0d all_acked %0d last %0d"},
							beats_seen, want_beat.kind, want_beat.send_chunk,
							want_beat.all_acked, want_beat.last,
							kind, send_chunk, all_acked, last);
				end
			end
		end
	end

	task automatic queue_item(input logic [srsw_pkg::OP_W-1:0] opc,
		input logic [srsw_pkg::CHUNK_W-1:0] ack);
		item_t it;
		it = '{op: opc, ack: ack};
		pending_items.push_back(it);
		items_pushed++;
	endtask

	// push one item and wait until the block takes it
	task automatic send_item(input logic [srsw_pkg::OP_W-1:0] opc,
		input logic [srsw_pkg::CHUNK_W-1:0] ack);
		queue_item(opc, ack);
		while (items_taken != items_pushed)
			@(negedge clk);
	endtask

	// wait until all items are taken, all beats are in and the block is idle
	task automatic settle();
		while (items_taken != items_pushed || beats_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [srsw_pkg::CFG_IDX_W-1:0] idx,
		input logic [srsw_pkg::CFG_W-1:0] data);
		settle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == srsw_pkg::REG_CHUNK_COUNT)
			cfg_count = data[srsw_pkg::CNT_W-1:0];
		else
			cfg_timeout = data[srsw_pkg::AGE_W-1:0];
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [srsw_pkg::CHUNK_W-1:0] rand_chunk();
		return srsw_pkg::CHUNK_W'($urandom_range(MAXC - 1, 0));
	endfunction

	initial begin : stim
		int r;
		int n;
		logic [srsw_pkg::CHUNK_W-1:0] pick;
		logic [srsw_pkg::CHUNK_W-1:0] live[$];

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: empty transfer, unused op code
		gap_max = 0;
		send_item(srsw_pkg::OP_TICK, rand_chunk());
		send_item(OP_NONE, 12'hFFF);

		// small transfer with a short timeout
		write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'd12);
		write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'd1);
		send_item(srsw_pkg::OP_START, 12'h000);
		send_item(srsw_pkg::OP_ACK, 12'd3);
		send_item(srsw_pkg::OP_ACK, 12'd11);      // not outstanding: only marks
		send_item(srsw_pkg::OP_ACK, 12'd12);      // at the count: ignored
		send_item(srsw_pkg::OP_ACK, 12'hFFF);     // beyond the count: ignored
		send_item(srsw_pkg::OP_ACK, 12'd0);
		send_item(srsw_pkg::OP_TICK, rand_chunk());
		send_item(srsw_pkg::OP_TICK, rand_chunk());
		send_item(OP_NONE, rand_chunk());

		// count lowered mid-transfer, then a zero timeout
		write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'd4);
		send_item(srsw_pkg::OP_TICK, rand_chunk());
		send_item(srsw_pkg::OP_TICK, rand_chunk());
		write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'd0);
		send_item(srsw_pkg::OP_TICK, rand_chunk());

		// count beyond the bitmap size is clipped
		write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'h1FFF);
		send_item(srsw_pkg::OP_START, rand_chunk());
		send_item(srsw_pkg::OP_ACK, 12'hFFF);
		send_item(srsw_pkg::OP_ACK, 12'h000);
		send_item(srsw_pkg::OP_TICK, rand_chunk());

		// upper data bits above the count width are dropped
		write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'hE003);
		write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
		send_item(srsw_pkg::OP_START, rand_chunk());
		send_item(srsw_pkg::OP_ACK, 12'd1);
		send_item(srsw_pkg::OP_ACK, 12'd0);
		send_item(srsw_pkg::OP_ACK, 12'd2);
		send_item(srsw_pkg::OP_TICK, rand_chunk());

		// empty transfer
		write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'd0);
		send_item(srsw_pkg::OP_START, rand_chunk());
		send_item(srsw_pkg::OP_ACK, 12'd0);

		// hold one chunk under a long timeout, then lower the timeout below its age
		write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'd1);
		send_item(srsw_pkg::OP_START, rand_chunk());
		for (int i = 0; i < 4; i++)
			queue_item(srsw_pkg::OP_TICK, rand_chunk());
		write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'd2);
		send_item(srsw_pkg::OP_TICK, rand_chunk());

		// random transfers, one register setting per phase
		for (int ph = 0; ph < 6; ph++) begin
			if ($urandom_range(7, 0) == 0)
				write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'd4096);
			else
				write_reg(srsw_pkg::REG_CHUNK_COUNT, 16'($urandom_range(70, 1)));
			if ($urandom_range(3, 0) == 0)
				write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(65535, 7)));
			else
				write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'($urandom_range(6, 0)));
			gap_max = (ph % 3 == 0) ? 0 : 12;
			// now and then keep the old transfer running under the new count
			if (ph == 0 || $urandom_range(3, 0) != 0)
				send_item(srsw_pkg::OP_START, rand_chunk());
			for (int i = 0; i < 32; i++) begin
				r = $urandom_range(99, 0);
				n = eff_count();
				live.delete();
				for (int s = 0; s < SLOTS; s++)
					if (slot_busy[s])
						live.push_back(slot_chunk[s]);
				if (r < 45 && live.size() > 0) begin
					pick = live[$urandom_range(live.size() - 1, 0)];
					send_item(srsw_pkg::OP_ACK, pick);
				end else if (r < 75) begin
					send_item(srsw_pkg::OP_TICK, rand_chunk());
				end else if (r < 85 && n > 0) begin
					send_item(srsw_pkg::OP_ACK,
						srsw_pkg::CHUNK_W'($urandom_range(n - 1, 0)));
				end else if (r < 92) begin
					send_item(srsw_pkg::OP_ACK, rand_chunk());
				end else if (r < 96) begin
					send_item(OP_NONE, rand_chunk());
				end else begin
					send_item(srsw_pkg::OP_START, rand_chunk());
				end
			end
		end

		settle();
		repeat (64) @(negedge clk);
		err_cnt += beats_due.size();

		$display("Run covered %0d items under %0d register writes.", items_taken, reg_writes);
		$display("Checked %0d result beats, %0d of them chunk sends; %0d failures.",
			beats_seen, sends_seen, err_cnt);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#8_000_000;
		$display("watchdog expired with %0d beats outstanding", beats_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
